@@ src/skvt_pkg.sv @@
// ============================================================================
// Sorted key/value table - shared package
// Widths, command codes and the structures that pass between the cell row,
// the combine stage and the top level.
// ============================================================================
`default_nettype none

package skvt_pkg;

    // Table geometry
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request commands (code 3 is unused and ignored)
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    // Operation broadcast to every cell in the apply cycle
    typedef struct packed {
        logic             ins;
        logic             rep;
        logic             rem;
        logic [IDX_W-1:0] pos;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_op;

    // Combined compare results of the whole row
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] vout;
        logic [CNT_W-1:0] ahead;
    } t_sum;

endpackage

`default_nettype wire

@@ src/skvt_if.sv @@
// ============================================================================
// Sorted key/value table - channel interfaces
// Valid/ready channels for requests, responses and the order register.
// ============================================================================
`default_nettype none

// Request channel: command, key and value
interface skvt_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic [skvt_pkg::KEY_W-1:0] key;
    logic [skvt_pkg::VAL_W-1:0] value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// Response channel: returned value, flags and entry count
interface skvt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [skvt_pkg::VAL_W-1:0] value_out;
    logic                       hit;
    logic                       rejected_full;
    logic [skvt_pkg::CNT_W-1:0] entry_count;

    modport source (output valid, output value_out, output hit, output rejected_full,
                    output entry_count, input ready);
    modport sink   (input valid, input value_out, input hit, input rejected_full,
                    input entry_count, output ready);
endinterface

// Configuration channel: sort order register
interface skvt_cfg_if;
    logic valid;
    logic ready;
    logic order_descending;

    modport source (output valid, output order_descending, input ready);
    modport sink   (input valid, input order_descending, output ready);
endinterface

`default_nettype wire

@@ src/skvt_cell.sv @@
// ============================================================================
// Sorted key/value table - storage cell
// Holds one key/value entry, compares it with the broadcast key and takes
// data from a neighbor when the row shifts.
// ============================================================================
`default_nettype none

module skvt_cell (
    input  wire logic                       i_clk,
    input  wire logic [skvt_pkg::IDX_W-1:0] i_index,
    input  wire logic [skvt_pkg::CNT_W-1:0] i_count,
    input  wire logic                       i_desc,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_bkey,
    input  wire skvt_pkg::t_cell_op         i_op,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_lo_key,
    input  wire logic [skvt_pkg::VAL_W-1:0] i_lo_val,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_hi_key,
    input  wire logic [skvt_pkg::VAL_W-1:0] i_hi_val,
    output logic      [skvt_pkg::KEY_W-1:0] o_key,
    output logic      [skvt_pkg::VAL_W-1:0] o_val,
    output logic                            o_eq,
    output logic                            o_prec
);

    logic [skvt_pkg::KEY_W-1:0] r_key, n_key;
    logic [skvt_pkg::VAL_W-1:0] r_val, n_val;
    logic                       r_eq, r_prec;
    logic                       occupied;
    logic                       at_pos, above_pos;

    assign occupied  = {1'b0, i_index} < i_count;
    assign at_pos    = i_index == i_op.pos;
    assign above_pos = i_index > i_op.pos;

    // Next entry: load the new item, take the lower neighbor on insert,
    // take the upper neighbor on remove, or replace the value in place.
    always_comb begin
        n_key = r_key;
        n_val = r_val;
        if (i_op.ins) begin
            if (at_pos) begin
                n_key = i_op.key;
                n_val = i_op.value;
            end else if (above_pos) begin
                n_key = i_lo_key;
                n_val = i_lo_val;
            end
        end else if (i_op.rem) begin
            if (at_pos || above_pos) begin
                n_key = i_hi_key;
                n_val = i_hi_val;
            end
        end else if (i_op.rep) begin
            if (at_pos) begin
                n_val = i_op.value;
            end
        end
    end

    // Entry storage and registered compare flags
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_val  <= n_val;
        r_eq   <= occupied && (r_key == i_bkey);
        r_prec <= occupied && (i_desc ? (r_key > i_bkey) : (r_key < i_bkey));
    end

    assign o_key  = r_key;
    assign o_val  = r_val;
    assign o_eq   = r_eq;
    assign o_prec = r_prec;

endmodule

`default_nettype wire

@@ src/skvt_reduce.sv @@
// ============================================================================
// Sorted key/value table - combine stage
// Merges the per-cell compare flags into hit, match index, found value and
// the count of entries that precede the key, and registers the result.
// ============================================================================
`default_nettype none

module skvt_reduce (
    input  wire logic                                i_clk,
    input  wire logic [skvt_pkg::CAPACITY-1:0]       i_eq,
    input  wire logic [skvt_pkg::CAPACITY-1:0]       i_prec,
    input  wire logic [skvt_pkg::VAL_W-1:0]          i_vals [skvt_pkg::CAPACITY],
    output skvt_pkg::t_sum                           o_sum
);

    skvt_pkg::t_sum             r_sum, n_sum;
    logic [skvt_pkg::CNT_W-1:0] part [skvt_pkg::CAPACITY];

    // Keys are unique, so at most one cell matches and plain ORs select it.
    // The preceding-entry count is a balanced adder tree.
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < skvt_pkg::CAPACITY; i++) begin
            n_sum.hit  = n_sum.hit | i_eq[i];
            n_sum.idx  = n_sum.idx | (i_eq[i] ? skvt_pkg::IDX_W'(i) : '0);
            n_sum.vout = n_sum.vout | (i_eq[i] ? i_vals[i] : '0);
            part[i]    = skvt_pkg::CNT_W'(i_prec[i]);
        end
        for (int step = 1; step < skvt_pkg::CAPACITY; step = step * 2) begin
            for (int j = 0; j + step < skvt_pkg::CAPACITY; j = j + 2 * step) begin
                part[j] = part[j] + part[j + step];
            end
        end
        n_sum.ahead = part[0];
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

@@ src/sorted_key_value_table_unit.sv @@
// ============================================================================
// Sorted key/value table unit
// Ordered map of unique keys in a row of cells; insert, lookup and remove.
// ============================================================================
//
//  Channel   Direction  Moves
//  i_req     in         command, key, value
//  o_rsp     out        value_out, hit, rejected_full, entry_count
//  i_cfg     in         order_descending (always ready)
//
//  A request passes through accept, cell compare, combine and apply in turn.
//  The next request is accepted only once apply has completed, so requests
//  never overlap; the compare-combine-shift sequence over the cell row sets this.
//  Reset clears the entry count and order register; there is no clearing pass.
//  The result waits in an output register; a new request is accepted while it
//  waits, and the apply step holds while the previous result is not taken.
// ============================================================================
`default_nettype none

module sorted_key_value_table_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    skvt_req_if.sink   i_req,
    skvt_rsp_if.source o_rsp,
    skvt_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_SUM   = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [1:0]                   r_cmd;
    logic [skvt_pkg::KEY_W-1:0]   r_key;
    logic [skvt_pkg::VAL_W-1:0]   r_value;
    logic [skvt_pkg::CNT_W-1:0]   r_count, n_count;
    logic                         r_desc;

    logic                         r_out_valid;
    logic [skvt_pkg::VAL_W-1:0]   r_vout, n_vout;
    logic                         r_hit, n_hit;
    logic                         r_rej, n_rej;

    skvt_pkg::t_cell_op           op_sel, cell_op;
    skvt_pkg::t_sum               sum;
    logic                         req_take, rsp_free, apply_go;

    logic [skvt_pkg::KEY_W-1:0]   cell_key  [skvt_pkg::CAPACITY];
    logic [skvt_pkg::VAL_W-1:0]   cell_val  [skvt_pkg::CAPACITY];
    logic [skvt_pkg::CAPACITY-1:0] cell_eq, cell_prec;

    assign i_req.ready = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;
    assign req_take    = i_req.valid && i_req.ready;
    assign rsp_free    = !r_out_valid || o_rsp.ready;
    assign apply_go    = (r_state == S_APPLY) && rsp_free;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (req_take) n_state = S_CMP;
            S_CMP:   n_state = S_SUM;
            S_SUM:   n_state = S_APPLY;
            S_APPLY: if (rsp_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Decide the cell operation and the response from the combined flags.
    always_comb begin
        op_sel       = '0;
        op_sel.key   = r_key;
        op_sel.value = r_value;
        n_count      = r_count;
        n_vout       = '0;
        n_hit        = 1'b0;
        n_rej        = 1'b0;
        unique case (skvt_pkg::t_cmd'(r_cmd))
            skvt_pkg::CMD_INSERT: begin
                if (sum.hit) begin
                    op_sel.rep = 1'b1;
                    op_sel.pos = sum.idx;
                    n_vout     = sum.vout;
                    n_hit      = 1'b1;
                end else if (r_count >= skvt_pkg::CNT_W'(skvt_pkg::CAPACITY)) begin
                    n_rej = 1'b1;
                end else begin
                    op_sel.ins = 1'b1;
                    op_sel.pos = sum.ahead[skvt_pkg::IDX_W-1:0];
                    n_count    = r_count + 1'b1;
                end
            end
            skvt_pkg::CMD_LOOKUP: begin
                n_vout = sum.vout;
                n_hit  = sum.hit;
            end
            skvt_pkg::CMD_REMOVE: begin
                if (sum.hit) begin
                    op_sel.rem = 1'b1;
                    op_sel.pos = sum.idx;
                    n_vout     = sum.vout;
                    n_hit      = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    // The row only sees an operation in the cycle the apply step completes.
    always_comb begin
        cell_op     = op_sel;
        cell_op.ins = op_sel.ins && apply_go;
        cell_op.rep = op_sel.rep && apply_go;
        cell_op.rem = op_sel.rem && apply_go;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_desc <= i_cfg.order_descending;
            end
            if (apply_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and response payload registers
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_cmd   <= i_req.command;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
        if (apply_go) begin
            r_vout <= n_vout;
            r_hit  <= n_hit;
            r_rej  <= n_rej;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.value_out     = r_vout;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.rejected_full = r_rej;
    assign o_rsp.entry_count   = r_count;

    // Row of cells, each linked to its lower and upper neighbor
    for (genvar g = 0; g < skvt_pkg::CAPACITY; g++) begin : g_cell
        logic [skvt_pkg::KEY_W-1:0] lo_key, hi_key;
        logic [skvt_pkg::VAL_W-1:0] lo_val, hi_val;

        if (g == 0) begin : g_first
            assign lo_key = r_key;
            assign lo_val = r_value;
        end else begin : g_lower
            assign lo_key = cell_key[g-1];
            assign lo_val = cell_val[g-1];
        end

        if (g == skvt_pkg::CAPACITY - 1) begin : g_last
            assign hi_key = cell_key[g];
            assign hi_val = cell_val[g];
        end else begin : g_upper
            assign hi_key = cell_key[g+1];
            assign hi_val = cell_val[g+1];
        end

        skvt_cell u_cell (
            .i_clk    (i_clk),
            .i_index  (skvt_pkg::IDX_W'(g)),
            .i_count  (r_count),
            .i_desc   (r_desc),
            .i_bkey   (r_key),
            .i_op     (cell_op),
            .i_lo_key (lo_key),
            .i_lo_val (lo_val),
            .i_hi_key (hi_key),
            .i_hi_val (hi_val),
            .o_key    (cell_key[g]),
            .o_val    (cell_val[g]),
            .o_eq     (cell_eq[g]),
            .o_prec   (cell_prec[g])
        );
    end

    // Combine stage
    skvt_reduce u_reduce (
        .i_clk  (i_clk),
        .i_eq   (cell_eq),
        .i_prec (cell_prec),
        .i_vals (cell_val),
        .o_sum  (sum)
    );

    // A full-table rejection never coincides with a hit.
    a_rej_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.rejected_full && o_rsp.hit))
        else $error("rejected_full together with hit");

    // A rejection is only reported with the table full.
    a_rej_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.rejected_full)
            |-> (o_rsp.entry_count == skvt_pkg::CNT_W'(skvt_pkg::CAPACITY)))
        else $error("rejection with table not full");

    // The entry count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= skvt_pkg::CNT_W'(skvt_pkg::CAPACITY))
        else $error("entry count above capacity");

    // An accepted request starts the compare step in the next cycle.
    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> (r_state == S_CMP))
        else $error("compare step did not follow accept");

endmodule

`default_nettype wire

@@ sim/tb_skvt_scoreboard_pkg.sv @@
// ============================================================================
// Sorted key/value table - scoreboard
// Keeps a behavioral copy of the ordered table, works out the response for
// each accepted request and compares the responses from the unit in order.
// ============================================================================
`timescale 1ns / 100ps

package tb_skvt_scoreboard_pkg;

    import skvt_pkg::*;

    // One expected response
    typedef struct {
        logic [VAL_W-1:0] value_out;
        logic             hit;
        logic             rejected_full;
        logic [CNT_W-1:0] entry_count;
    } t_table_reply;

    class table_scoreboard;

        logic [KEY_W-1:0] keys[CAPACITY];
        logic [VAL_W-1:0] vals[CAPACITY];
        int unsigned      count;
        bit               descending;
        t_table_reply     replies[$];
        int unsigned      mismatches;

        function new();
            count      = 0;
            descending = 1'b0;
            mismatches = 0;
        endfunction

        function void set_order(bit desc);
            descending = desc;
        endfunction

        function int unsigned outstanding();
            return replies.size();
        endfunction

        function int unsigned held();
            return count;
        endfunction

        // A random key out of those currently held.
        function logic [KEY_W-1:0] held_key();
            return keys[$urandom_range(0, count - 1)];
        endfunction

        // True when a stored key comes strictly ahead of the given key.
        function bit comes_ahead(logic [KEY_W-1:0] stored, logic [KEY_W-1:0] key);
            return descending ? (stored > key) : (stored < key);
        endfunction

        // Apply one accepted request to the table copy and queue its response.
        function void note_request(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
            t_table_reply rep;
            int unsigned  match;
            int unsigned  ahead;
            rep   = '{value_out: '0, hit: 1'b0, rejected_full: 1'b0, entry_count: '0};
            match = 0;
            ahead = 0;

            // Equality against every held entry; order only counts the slot.
            for (int unsigned i = 0; i < count; i++) begin
                if (keys[i] == key && !rep.hit) begin
                    rep.hit = 1'b1;
                    match   = i;
                end
                if (comes_ahead(keys[i], key)) ahead++;
            end

            case (cmd)
                CMD_INSERT: begin
                    if (rep.hit) begin
                        rep.value_out = vals[match];
                        vals[match]   = value;
                    end else if (count >= CAPACITY) begin
                        rep.rejected_full = 1'b1;
                    end else begin
                        for (int unsigned i = count; i > ahead; i--) begin
                            keys[i] = keys[i-1];
                            vals[i] = vals[i-1];
                        end
                        keys[ahead] = key;
                        vals[ahead] = value;
                        count++;
                    end
                end
                CMD_LOOKUP: begin
                    if (rep.hit) rep.value_out = vals[match];
                end
                CMD_REMOVE: begin
                    if (rep.hit) begin
                        rep.value_out = vals[match];
                        for (int unsigned i = match; i + 1 < count; i++) begin
                            keys[i] = keys[i+1];
                            vals[i] = vals[i+1];
                        end
                        count--;
                    end
                end
                default: begin
                    rep.hit = 1'b0;
                end
            endcase

            rep.entry_count = CNT_W'(count);
            replies.push_back(rep);
        endfunction

        // Compare one response from the unit with the oldest expectation.
        function void check_reply(logic [VAL_W-1:0] value_out, logic hit,
                                  logic rejected_full, logic [CNT_W-1:0] entry_count);
            t_table_reply exp_rep;
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with none expected: value %h hit %b full %b count %0d",
                             $time, value_out, hit, rejected_full, entry_count);
                return;
            end
            exp_rep = replies.pop_front();
            if (value_out !== exp_rep.value_out || hit !== exp_rep.hit ||
                rejected_full !== exp_rep.rejected_full ||
                entry_count !== exp_rep.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response mismatch: expected value %h hit %b full %b count %0d, got value %h hit %b full %b count %0d",
                             $time, exp_rep.value_out, exp_rep.hit, exp_rep.rejected_full,
                             exp_rep.entry_count, value_out, hit, rejected_full, entry_count);
            end
        endfunction

    endclass

endpackage

@@ sim/tb_sorted_key_value_table_unit.sv @@
// ============================================================================
// Sorted key/value table unit - testbench
// Drives insert, lookup, remove and unused requests in directed and random
// phases under both sort orders, with random gaps and response stalls, and
// checks every response against the scoreboard's copy of the table.
// ============================================================================
`timescale 1ns / 100ps

module tb_sorted_key_value_table_unit;

    import skvt_pkg::*;
    import tb_skvt_scoreboard_pkg::*;

    // Code 3 is not a command; the unit must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         POOL_SIZE  = 80;

    logic clk;
    logic rst_n;
    bit   quiet;

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    table_scoreboard sb = new();

    skvt_req_if req_ch ();
    skvt_rsp_if rsp_ch ();
    skvt_cfg_if cfg_ch ();

    sorted_key_value_table_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request and wait until it is accepted.
    task automatic push_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        @(negedge clk);
        req_ch.valid   = 1'b1;
        req_ch.command = cmd;
        req_ch.key     = key;
        req_ch.value   = value;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        sb.note_request(cmd, key, value);
    endtask

    // Hold the request channel idle for a number of cycles, with junk payload.
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            req_ch.valid   = 1'b0;
            req_ch.command = 2'($urandom);
            req_ch.key     = $urandom;
            req_ch.value   = $urandom;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every expected response has come.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (sb.outstanding() > 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write the order register while the unit is idle.
    task automatic write_order(input bit desc);
        wait_drained();
        @(negedge clk);
        cfg_ch.valid            = 1'b1;
        cfg_ch.order_descending = desc;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.set_order(desc);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Keys come from a shared pool, from the held entries, or fully random.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 80 && sb.held() > 0) return sb.held_key();
        return $urandom;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // One random phase: a command mix, a request count and one sort order.
    task automatic run_phase(input bit desc, input int ins_pct, input int look_pct,
                             input int items, input bit no_idle);
        int r;
        logic [1:0] cmd;
        write_order(desc);
        quiet = no_idle;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) cmd = CMD_INSERT;
            else if (r < ins_pct + look_pct) cmd = CMD_LOOKUP;
            else if (r < 97) cmd = CMD_REMOVE;
            else cmd = CMD_UNUSED;
            push_request(cmd, pick_key(), pick_value());
            // Let everything in flight come back once in the middle of the phase.
            if (n == items / 2) wait_drained();
            else hold_off(pick_pause());
        end
        quiet = 1'b0;
    endtask

    // Response side: check on accept, then choose ready for the next cycle.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_reply(rsp_ch.value_out, rsp_ch.hit, rsp_ch.rejected_full,
                               rsp_ch.entry_count);
            @(negedge clk);
            if (stall_left > 0) begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready = 1'b1;
                stall_left   = pick_pause();
            end
        end
    end

    // Stimulus
    initial begin
        quiet                   = 1'b0;
        rst_n                   = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.command          = CMD_INSERT;
        req_ch.key              = '0;
        req_ch.value            = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.order_descending = 1'b0;

        // The pool holds the key extremes and a spread of random keys.
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'h0000_0001;
        key_pool[3] = 32'h7FFF_FFFF;
        key_pool[4] = 32'h8000_0000;
        for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: misses on an empty table, extremes, replace, unused code.
        write_order(1'b0);
        push_request(CMD_LOOKUP, 32'd5, 32'h1111_1111);
        push_request(CMD_REMOVE, 32'd5, '0);
        push_request(CMD_INSERT, 32'd500, '0);
        push_request(CMD_INSERT, '0, '1);
        push_request(CMD_INSERT, '1, 32'h0000_1234);
        push_request(CMD_INSERT, 32'd250, 32'hA5A5_A5A5);
        push_request(CMD_LOOKUP, '0, '0);
        push_request(CMD_LOOKUP, '1, '0);
        push_request(CMD_INSERT, 32'd250, 32'h5A5A_5A5A);
        push_request(CMD_UNUSED, 32'd250, '1);
        push_request(CMD_LOOKUP, 32'd250, '0);
        push_request(CMD_REMOVE, '0, '0);
        push_request(CMD_REMOVE, '0, '0);
        push_request(CMD_LOOKUP, '0, '0);

        // Order flipped with entries held: they stay where they are.
        write_order(1'b1);
        push_request(CMD_INSERT, 32'd300, 32'hDEAD_0001);
        push_request(CMD_INSERT, 32'd1, 32'hDEAD_0002);
        push_request(CMD_INSERT, 32'hFFFF_FFFE, 32'hDEAD_0003);
        push_request(CMD_LOOKUP, 32'd500, '0);
        push_request(CMD_REMOVE, 32'd250, '0);
        push_request(CMD_UNUSED, '1, '0);

        // Random: fill to capacity, mix, drain, refill without idling, mix.
        run_phase(1'b1, 100, 0, 80, 1'b0);
        run_phase(1'b0, 45, 35, 120, 1'b0);
        run_phase(1'b1, 20, 30, 120, 1'b0);
        run_phase(1'b0, 85, 10, 110, 1'b1);
        run_phase(1'b1, 50, 30, 110, 1'b0);
        run_phase(1'b0, 40, 30, 100, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("PASS sorted_key_value_table_unit");
        end else begin
            $display("FAIL sorted_key_value_table_unit");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAIL sorted_key_value_table_unit");
        $finish;
    end

endmodule

@@ filelist.f @@
src/skvt_pkg.sv
src/skvt_if.sv
src/skvt_cell.sv
src/skvt_reduce.sv
src/sorted_key_value_table_unit.sv
sim/tb_skvt_scoreboard_pkg.sv
sim/tb_sorted_key_value_table_unit.sv
